/* hw/rtl/rx_byte_queue_with_realtime_filter_defines.svh */
// ----------------------------------------------------------------------------
// Receive byte queue: assertion macros
// Shared concurrent assertion forms, clocked on clk_i and off during reset.
// ----------------------------------------------------------------------------
`ifndef RX_BYTE_QUEUE_WITH_REALTIME_FILTER_DEFINES_SVH
`define RX_BYTE_QUEUE_WITH_REALTIME_FILTER_DEFINES_SVH

// same-cycle implication
`define RBQ_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rbq assertion failed");

// next-cycle implication
`define RBQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rbq assertion failed");

`endif

/* hw/rtl/rbq_pkg.sv */
// ----------------------------------------------------------------------------
// Receive byte queue package
// Beat types, action and register codes, and controller/datapath links.
// ----------------------------------------------------------------------------
package rbq_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned COUNT_W = 8;
  localparam int unsigned CODES   = 4;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [BYTE_W-1:0] EXTENDED_LIMIT = 8'h7F;

  typedef enum logic [1:0] {
    ACT_RX    = 2'd0,
    ACT_READ  = 2'd1,
    ACT_FLUSH = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CODE_RESET       = 2'd0,
    REG_CODE_STATUS      = 2'd1,
    REG_CODE_CYCLE_START = 2'd2,
    REG_CODE_FEED_HOLD   = 2'd3
  } reg_idx_e;

  localparam logic [BYTE_W-1:0] CODE_RESET_INIT       = 8'd24;
  localparam logic [BYTE_W-1:0] CODE_STATUS_INIT      = 8'd63;
  localparam logic [BYTE_W-1:0] CODE_CYCLE_START_INIT = 8'd126;
  localparam logic [BYTE_W-1:0] CODE_FEED_HOLD_INIT   = 8'd33;

  typedef struct packed {
    logic [1:0]        action;
    logic [BYTE_W-1:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  read_data;
    logic               read_valid;
    logic               realtime_hit;
    logic [BYTE_W-1:0]  realtime_code;
    logic               overflow_drop;
    logic [COUNT_W-1:0] used_count;
    logic [COUNT_W-1:0] free_count;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage

/* hw/rtl/rbq_ctrl.sv */
// ----------------------------------------------------------------------------
// Receive byte queue controller
// Two-state sequencer: take one beat, then run it once the output is free.
// ----------------------------------------------------------------------------
module rbq_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  rbq_pkg::sts_t sts_i,
  output rbq_pkg::cmd_t cmd_o
);
  import rbq_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d     = state_q;
    cmd_o.load  = 1'b0;
    cmd_o.exec  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // hold until the result register can take the beat
        if (sts_i.out_free) begin
          cmd_o.exec = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* hw/rtl/rbq_dp.sv */
// ----------------------------------------------------------------------------
// Receive byte queue datapath
// Code registers, realtime filter, ring memory, pointers and result register.
// ----------------------------------------------------------------------------
`include "rx_byte_queue_with_realtime_filter_defines.svh"

module rbq_dp #(
  parameter int unsigned QUEUE_BYTES = 128
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [rbq_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [rbq_pkg::BYTE_W-1:0]        cfg_data_i,
  input  rbq_pkg::in_t                      in_item_i,
  input  rbq_pkg::cmd_t                     cmd_i,
  output rbq_pkg::sts_t                     sts_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output rbq_pkg::out_t                     out_item_o
);
  import rbq_pkg::*;

  localparam int unsigned SLOTS = QUEUE_BYTES + 1;
  localparam int unsigned IDX_W = $clog2(SLOTS);
  localparam int unsigned CNT_W = $clog2(QUEUE_BYTES + 1);
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(SLOTS - 1);
  localparam logic [CNT_W-1:0] CAPACITY  = CNT_W'(QUEUE_BYTES);

  logic [BYTE_W-1:0] code_q [CODES];
  logic [BYTE_W-1:0] mem [SLOTS];
  logic [BYTE_W-1:0] rd_data_q;
  in_t               item_q;
  logic [IDX_W-1:0]  wr_idx_q, wr_idx_d, rd_idx_q, rd_idx_d;
  logic [CNT_W-1:0]  used_q, used_d;
  logic              out_valid_q;
  out_t              out_q, res;
  logic              is_rt, full, empty, mem_we, is_read;

  function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] idx);
    return (idx == LAST_SLOT) ? '0 : idx + 1'b1;
  endfunction

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_q[REG_CODE_RESET]       <= CODE_RESET_INIT;
      code_q[REG_CODE_STATUS]      <= CODE_STATUS_INIT;
      code_q[REG_CODE_CYCLE_START] <= CODE_CYCLE_START_INIT;
      code_q[REG_CODE_FEED_HOLD]   <= CODE_FEED_HOLD_INIT;
    end else if (cfg_we_i) begin
      code_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_item_i;
    end
  end

  assign is_rt = (item_q.rx_byte == code_q[REG_CODE_RESET])
              || (item_q.rx_byte == code_q[REG_CODE_STATUS])
              || (item_q.rx_byte == code_q[REG_CODE_CYCLE_START])
              || (item_q.rx_byte == code_q[REG_CODE_FEED_HOLD])
              || (item_q.rx_byte > EXTENDED_LIMIT);
  assign full    = (used_q == CAPACITY);
  assign empty   = (used_q == '0);
  assign is_read = (item_q.action == ACT_READ);

  always_comb begin
    res      = '0;
    wr_idx_d = wr_idx_q;
    rd_idx_d = rd_idx_q;
    used_d   = used_q;
    mem_we   = 1'b0;
    case (item_q.action)
      ACT_RX: begin
        if (is_rt) begin
          res.realtime_hit  = 1'b1;
          res.realtime_code = item_q.rx_byte;
        end else if (full) begin
          res.overflow_drop = 1'b1;
        end else begin
          mem_we   = 1'b1;
          wr_idx_d = next_slot(wr_idx_q);
          used_d   = used_q + 1'b1;
        end
      end
      ACT_READ: begin
        if (!empty) begin
          res.read_data  = rd_data_q;
          res.read_valid = 1'b1;
          rd_idx_d       = next_slot(rd_idx_q);
          used_d         = used_q - 1'b1;
        end
      end
      ACT_FLUSH: begin
        rd_idx_d = wr_idx_q;
        used_d   = '0;
      end
      default: ;
    endcase
    res.used_count = COUNT_W'(used_d);
    res.free_count = COUNT_W'(CAPACITY - used_d);
  end

  // ring memory; read port always follows the oldest slot
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && mem_we) begin
      mem[wr_idx_q] <= item_q.rx_byte;
    end
    rd_data_q <= mem[rd_idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_idx_q <= '0;
      rd_idx_q <= '0;
      used_q   <= '0;
    end else if (cmd_i.exec) begin
      wr_idx_q <= wr_idx_d;
      rd_idx_q <= rd_idx_d;
      used_q   <= used_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.exec) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      out_q <= res;
    end
  end

  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign out_item_o     = out_q;

  `RBQ_ASSERT_IMPL(a_used_max, 1'b1, used_q <= CAPACITY)
  `RBQ_ASSERT_IMPL(a_empty_ptrs, used_q == '0, wr_idx_q == rd_idx_q)
  `RBQ_ASSERT_NEXT(a_pop_count, cmd_i.exec && is_read && !empty, used_q == $past(used_q) - 1'b1)
  `RBQ_ASSERT_NEXT(a_exec_shows, cmd_i.exec, out_valid_q)

endmodule

/* hw/rtl/rx_byte_queue_with_realtime_filter.sv */
// ----------------------------------------------------------------------------
// Receive byte queue with realtime filter
// Filters realtime command bytes out of a serial receive stream and queues
// the rest in a ring; supports read and flush.
// ----------------------------------------------------------------------------
//  channel  | signals                            | dir | beat when
//  ---------+------------------------------------+-----+------------------------
//  in       | in_valid_i/in_ready_o, in_item_i   | in  | valid & ready
//  out      | out_valid_o/out_ready_i, out_item_o| out | valid & ready
//  cfg      | cfg_we_i, cfg_idx_i, cfg_data_i    | in  | cfg_we_i high
//
//  Each beat is latched in ST_IDLE while the ring memory reads the oldest
//  slot into its output register, and is applied in ST_EXEC.
//  The input is taken again while a finished result waits on the output.
//  A stall on the output holds the next beat in ST_EXEC.
//  Reset clears pointers and counts and loads the default command codes;
//  no clearing pass.
// ----------------------------------------------------------------------------
module rx_byte_queue_with_realtime_filter #(
  parameter int unsigned QUEUE_BYTES = 128
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rbq_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [rbq_pkg::BYTE_W-1:0]    cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  rbq_pkg::in_t                  in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output rbq_pkg::out_t                 out_item_o
);
  import rbq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  rbq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rbq_dp #(
    .QUEUE_BYTES (QUEUE_BYTES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule
